// ===== hw/rtl/tecm_pkg.sv =====
// Shared types and constants for the tab-expanded column mapper.
package tecm_pkg;

    localparam int unsigned POS_WIDTH_DEFAULT = 16;
    localparam int unsigned TGT_W = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned TS_W = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CHAR_W-1:0] TAB_CHAR = 8'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPAND_TABS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE = 1'd1;

    localparam logic EXPAND_TABS_RESET = 1'b1;
    localparam logic [TS_W-1:0] TAB_SIZE_RESET = 7'd8;

    localparam logic OP_OFS_TO_COL = 1'b0;
    localparam logic OP_COL_TO_OFS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } tecm_state_t;

endpackage

// ===== hw/rtl/tecm_div.sv =====
// Bit-serial remainder unit: dividend modulo a narrow divisor, one bit per cycle.
module tecm_div #(
    parameter int unsigned W = tecm_pkg::POS_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [W-1:0]                dividend,
    input  logic [tecm_pkg::TS_W-1:0]   divisor,
    output logic                        done,
    output logic [tecm_pkg::TS_W-1:0]   remainder
);
    import tecm_pkg::*;

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]      shift_reg, shift_next;
    logic [TS_W-1:0]   rem_reg, rem_next;
    logic [TS_W-1:0]   div_reg, div_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TS_W:0]     trial;
    logic [TS_W:0]     diff;

    always_comb
    begin
        trial = {rem_reg, shift_reg[W-1]};
        diff = trial - {1'b0, div_reg};
        shift_next = shift_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            shift_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << 1;
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[TS_W-1:0];
            end
            else
            begin
                rem_next = trial[TS_W-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/tab_expanded_column_mapper.sv =====
// Top level: line sequencer and datapath of the tab-expanded column mapper.
// Steps: an item without a tab advance goes from IDLE through UPDATE; a tab that advances the
// column also passes through DIV, where the bit-serial remainder unit works.
// The last item of a line also passes through FINISH, then the result sits in the output register.
// A new item is taken only in IDLE; in_stall is high while an item works.
// Reset: expand_tabs = 1, tab_size = 8, line state cleared, no result pending.
module tab_expanded_column_mapper #(
    parameter int unsigned POS_WIDTH = tecm_pkg::POS_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [tecm_pkg::TGT_W-1:0]        target,
    input  logic [tecm_pkg::CHAR_W-1:0]       char_byte,
    input  logic                              has_char,
    input  logic                              last_char,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tecm_pkg::TGT_W-1:0]        position,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tecm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tecm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tecm_pkg::*;

    localparam int unsigned TW = (POS_WIDTH > TGT_W) ? POS_WIDTH : TGT_W;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    tecm_state_t state_reg, state_next;

    logic                  expand_reg;
    logic [TS_W-1:0]       tab_size_reg;
    logic [POS_WIDTH-1:0]  column_reg, column_next;
    logic [POS_WIDTH-1:0]  index_reg, index_next;
    logic                  found_reg, found_next;
    logic [POS_WIDTH-1:0]  held_reg, held_next;
    logic                  op_reg;
    logic [POS_WIDTH-1:0]  target_reg;
    logic                  tab_reg;
    logic                  has_reg;
    logic                  last_reg;
    logic                  adv_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [TGT_W-1:0]      position_reg;

    logic                  accept;
    logic                  div_start;
    logic                  div_done;
    logic [TS_W-1:0]       div_rem;
    logic                  do_update;
    logic                  load_out;
    logic                  busy;

    logic [TW-1:0]         tgt_wide;
    logic [POS_WIDTH-1:0]  tgt_in;
    logic                  adv_now;
    logic                  tab_now;
    logic [TS_W-1:0]       tab_eff;
    logic [POS_WIDTH:0]    inc_sum;
    logic [POS_WIDTH-1:0]  inc_col;
    logic [POS_WIDTH-1:0]  tab_base;
    logic [POS_WIDTH:0]    tab_sum;
    logic [POS_WIDTH-1:0]  tab_col;
    logic [POS_WIDTH-1:0]  new_col;
    logic [POS_WIDTH:0]    idx_sum;

    logic [POS_WIDTH:0]    fwd_sum;
    logic [POS_WIDTH:0]    rev_sum;
    logic [POS_WIDTH-1:0]  result;
    logic [TW-1:0]         result_wide;

    // Saturate target into the position width and decode the incoming item.
    always_comb
    begin
        tgt_wide = TW'(target);
        if (tgt_wide > TW'(POS_MAX))
        begin
            tgt_in = POS_MAX;
        end
        else
        begin
            tgt_in = tgt_wide[POS_WIDTH-1:0];
        end
        adv_now = has_char && ((operation == OP_COL_TO_OFS) || (index_reg < tgt_in));
        tab_now = (char_byte == TAB_CHAR);
        tab_eff = (tab_size_reg == '0) ? TS_W'(1) : tab_size_reg;
    end

    assign accept = in_valid && !in_stall;

    tecm_div #(
        .W(POS_WIDTH)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(column_reg),
        .divisor(tab_eff),
        .done(div_done),
        .remainder(div_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (adv_now && tab_now) ? ST_DIV : ST_UPDATE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy = 1'b1;
        div_start = 1'b0;
        do_update = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                div_start = accept && adv_now && tab_now;
            end
            ST_DIV:
            begin
                busy = 1'b1;
            end
            ST_UPDATE:
            begin
                do_update = 1'b1;
            end
            ST_FINISH:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign in_stall = busy;

    // Column and index advance.
    always_comb
    begin
        inc_sum = {1'b0, column_reg} + (POS_WIDTH + 1)'(1);
        inc_col = inc_sum[POS_WIDTH] ? POS_MAX : inc_sum[POS_WIDTH-1:0];
        tab_base = column_reg - POS_WIDTH'(div_rem);
        tab_sum = {1'b0, tab_base} + (POS_WIDTH + 1)'(tab_eff);
        tab_col = tab_sum[POS_WIDTH] ? POS_MAX : tab_sum[POS_WIDTH-1:0];
        if (adv_reg)
        begin
            new_col = tab_reg ? tab_col : inc_col;
        end
        else
        begin
            new_col = column_reg;
        end
        idx_sum = {1'b0, index_reg} + (POS_WIDTH + 1)'(1);
    end

    // Final mapping.
    always_comb
    begin
        fwd_sum = {1'b0, column_reg} + {1'b0, target_reg - index_reg};
        rev_sum = {1'b0, index_reg} + {1'b0, target_reg - column_reg};
        if (!expand_reg)
        begin
            result = target_reg;
        end
        else if (op_reg == OP_OFS_TO_COL)
        begin
            if (index_reg < target_reg)
            begin
                result = fwd_sum[POS_WIDTH] ? POS_MAX : fwd_sum[POS_WIDTH-1:0];
            end
            else
            begin
                result = column_reg;
            end
        end
        else
        begin
            if (found_reg)
            begin
                result = held_reg;
            end
            else if (target_reg >= column_reg)
            begin
                result = rev_sum[POS_WIDTH] ? POS_MAX : rev_sum[POS_WIDTH-1:0];
            end
            else
            begin
                result = index_reg;
            end
        end
        result_wide = TW'(result);
    end

    // Line state.
    always_comb
    begin
        column_next = column_reg;
        index_next = index_reg;
        found_next = found_reg;
        held_next = held_reg;
        if (load_out)
        begin
            column_next = '0;
            index_next = '0;
            found_next = 1'b0;
            held_next = '0;
        end
        else if (do_update && has_reg)
        begin
            column_next = new_col;
            index_next = idx_sum[POS_WIDTH] ? POS_MAX : idx_sum[POS_WIDTH-1:0];
            if ((op_reg == OP_COL_TO_OFS) && !found_reg && (new_col > target_reg))
            begin
                found_next = 1'b1;
                held_next = index_reg;
            end
        end
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            expand_reg <= EXPAND_TABS_RESET;
            tab_size_reg <= TAB_SIZE_RESET;
            column_reg <= '0;
            index_reg <= '0;
            found_reg <= 1'b0;
            held_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            column_reg <= column_next;
            index_reg <= index_next;
            found_reg <= found_next;
            held_reg <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EXPAND_TABS)
                begin
                    expand_reg <= cfg_data[0];
                end
                else if (cfg_index == CFG_TAB_SIZE)
                begin
                    tab_size_reg <= cfg_data;
                end
            end
        end
    end

    // Hold the accepted transaction and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= operation;
            target_reg <= tgt_in;
            tab_reg <= tab_now;
            has_reg <= has_char;
            last_reg <= last_char;
            adv_reg <= adv_now;
        end
        if (load_out)
        begin
            position_reg <= result_wide[TGT_W-1:0];
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign position = position_reg;

endmodule

// ===== dv/tab_expanded_column_mapper_tb.sv =====
// Self-checking testbench for the tab-expanded column mapper: streamed lines, predicted positions.
`timescale 1ns / 100ps

module tab_expanded_column_mapper_tb;
    import tecm_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 85;

    typedef struct packed {
        bit            op;
        bit [TGT_W-1:0] tgt;
        bit [CHAR_W-1:0] ch;
        bit            has_ch;
        bit            is_last;
    } line_item_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [TGT_W-1:0]     position;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    line_item_t           cur_item = '0;
    line_item_t           pending_items[$];
    logic [TGT_W-1:0]     expected_positions[$];
    bit                   item_taken = 1'b0;
    bit                   no_idle = 1'b0;
    bit                   holdoff_req = 1'b0;
    int unsigned          holdoff_left = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          fail_count = 0;
    int unsigned          planned_items = 0;

    // predictor state and configuration
    logic                 expand_on = EXPAND_TABS_RESET;
    logic [TS_W-1:0]      tab_stop = TAB_SIZE_RESET;
    logic [TGT_W-1:0]     col_seen = '0;
    logic [TGT_W-1:0]     chars_seen = '0;
    logic                 crossing_found = 1'b0;
    logic [TGT_W-1:0]     crossing_ofs = '0;
    logic [TGT_W-1:0]     want;

    tab_expanded_column_mapper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (cur_item.op),
        .target    (cur_item.tgt),
        .char_byte (cur_item.ch),
        .has_char  (cur_item.has_ch),
        .last_char (cur_item.is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [TGT_W-1:0] clamp_pos(int unsigned v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[TGT_W-1:0];
    endfunction

    function automatic logic [TGT_W-1:0] step_column(logic [TGT_W-1:0] col,
                                                     logic [CHAR_W-1:0] ch);
        int unsigned stop;
        stop = (tab_stop == 0) ? 1 : tab_stop;
        if (ch != TAB_CHAR)
            return clamp_pos(int'(col) + 1);
        return clamp_pos((int'(col) / stop + 1) * stop);
    endfunction

    function automatic void track_item(line_item_t it);
        logic [TGT_W-1:0] pos;
        if (it.has_ch)
        begin
            if (it.op == OP_OFS_TO_COL)
            begin
                if (chars_seen < it.tgt)
                    col_seen = step_column(col_seen, it.ch);
            end
            else
            begin
                col_seen = step_column(col_seen, it.ch);
                if (!crossing_found && col_seen > it.tgt)
                begin
                    crossing_found = 1'b1;
                    crossing_ofs = chars_seen;
                end
            end
            chars_seen = clamp_pos(int'(chars_seen) + 1);
        end
        if (!it.is_last)
            return;
        if (!expand_on)
            pos = it.tgt;
        else if (it.op == OP_OFS_TO_COL)
            pos = (chars_seen < it.tgt) ?
                  clamp_pos(int'(col_seen) + int'(it.tgt) - int'(chars_seen)) : col_seen;
        else if (crossing_found)
            pos = crossing_ofs;
        else if (it.tgt >= col_seen)
            pos = clamp_pos(int'(chars_seen) + int'(it.tgt) - int'(col_seen));
        else
            pos = chars_seen;
        expected_positions.push_back(pos);
        col_seen = '0;
        chars_seen = '0;
        crossing_found = 1'b0;
        crossing_ofs = '0;
    endfunction

    // input side: predict on acceptance, drive the next transaction at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            track_item(cur_item);
            item_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 16))
            begin
                cur_item = pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_positions.size() == 0)
            begin
                if (fail_count < 10)
                    $display("ERROR: unexpected result position=%0d", position);
                fail_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (position !== want)
                begin
                    if (fail_count < 10)
                        $display("ERROR: position expected %0d actual %0d", want, position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic add_item(bit op, bit [TGT_W-1:0] tgt, bit [CHAR_W-1:0] ch,
                            bit has_ch, bit is_last);
        line_item_t it;
        it.op = op;
        it.tgt = tgt;
        it.ch = ch;
        it.has_ch = has_ch;
        it.is_last = is_last;
        pending_items.push_back(it);
        planned_items++;
    endtask

    task automatic add_text(bit op, bit [TGT_W-1:0] tgt, string s);
        if (s.len() == 0)
            add_item(op, tgt, 8'd0, 1'b0, 1'b1);
        for (int i = 0; i < s.len(); i++)
            add_item(op, tgt, s[i], 1'b1, i == s.len() - 1);
    endtask

    task automatic add_random_line();
        int unsigned len;
        bit op;
        bit [TGT_W-1:0] tgt;
        bit [CHAR_W-1:0] ch;
        bit open_end;
        len = ($urandom_range(99) < 8) ? $urandom_range(20, 40) : $urandom_range(0, 12);
        op = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: tgt = '0;
            1: tgt = '1;
            2: tgt = TGT_W'($urandom_range(0, len + 2));
            3: tgt = TGT_W'($urandom_range(0, len * 9 + 8));
            4: tgt = TGT_W'($urandom_range(0, 65535));
            default: tgt = TGT_W'($urandom_range(0, 31));
        endcase
        open_end = (len == 0) || ($urandom_range(99) < 20);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                add_item(op, tgt, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if ($urandom_range(99) < 4)
            begin
                op = 1'($urandom_range(1));
                tgt = TGT_W'($urandom_range(0, 65535));
            end
            ch = ($urandom_range(99) < 35) ? TAB_CHAR : 8'($urandom_range(0, 255));
            add_item(op, tgt, ch, 1'b1, !open_end && i == len - 1);
        end
        if (open_end)
            add_item(op, tgt, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_positions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_EXPAND_TABS)
            expand_on = data[0];
        else
            tab_stop = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        static bit expand_set[8] = '{1, 1, 1, 0, 1, 1, 1, 1};
        static int unsigned stop_set[8] = '{8, 1, 64, 8, 0, 127, 3, 5};
        int unsigned phase_start;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        add_text(OP_OFS_TO_COL, 16'd0, "");
        add_text(OP_COL_TO_OFS, 16'hFFFF, "");
        add_text(OP_OFS_TO_COL, 16'd2, "a\tb");
        add_text(OP_COL_TO_OFS, 16'd9, "\t\t");
        add_text(OP_OFS_TO_COL, 16'hFFFF, "\t");
        add_item(OP_COL_TO_OFS, 16'd3, "x", 1'b1, 1'b0);
        add_item(OP_COL_TO_OFS, 16'd3, TAB_CHAR, 1'b1, 1'b0);
        add_item(OP_COL_TO_OFS, 16'd3, 8'd0, 1'b0, 1'b1);
        add_item(OP_OFS_TO_COL, 16'd3, TAB_CHAR, 1'b1, 1'b0);
        add_item(OP_COL_TO_OFS, 16'd5, "q", 1'b1, 1'b1);
        add_item(OP_OFS_TO_COL, 16'd0, 8'hFF, 1'b1, 1'b0);
        add_item(OP_OFS_TO_COL, 16'd0, 8'h00, 1'b1, 1'b1);
        add_item(OP_OFS_TO_COL, 16'd10, TAB_CHAR, 1'b1, 1'b0);
        add_item(OP_OFS_TO_COL, 16'd10, "a", 1'b1, 1'b0);
        settle();
        program_reg(CFG_EXPAND_TABS, 7'd0);
        add_item(OP_OFS_TO_COL, 16'd10, "b", 1'b1, 1'b1);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            program_reg(CFG_EXPAND_TABS, {6'($urandom_range(0, 63)), expand_set[p]});
            program_reg(CFG_TAB_SIZE, 7'(stop_set[p]));
            no_idle = (p == 2);
            if (p == 3)
                holdoff_req = 1'b1;
            if (stop_set[p] == 127)
            begin
                // enough tabs to drive the column into saturation
                for (int i = 0; i < 520; i++)
                    add_item(OP_OFS_TO_COL, 16'd520, TAB_CHAR, 1'b1, i == 519);
            end
            phase_start = planned_items;
            while (planned_items - phase_start < PHASE_ITEMS)
                add_random_line();
            settle();
        end
        no_idle = 1'b0;

        if (fail_count == 0 && expected_positions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tecm_pkg.sv
hw/rtl/tecm_div.sv
hw/rtl/tab_expanded_column_mapper.sv
dv/tab_expanded_column_mapper_tb.sv
